FILE: sv/assert_macros.svh
// assertion macros shared by the dda line point generator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, off while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every rising edge of clk, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/dda_pkg.sv
// shared types and constants of the dda line point generator
`default_nettype none

package dda_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  // biased position: two guard bits, integer part, fraction
  localparam int POS_BITS  = COORD_BITS + FRAC_BITS + 2;
  // quotient of |d| * 2^FRAC_BITS / step, at most 1.0
  localparam int QUO_BITS  = FRAC_BITS + 1;
  // signed increment
  localparam int INC_BITS  = QUO_BITS + 1;
  // remaining point count, holds up to the largest step
  localparam int STEP_BITS = COORD_BITS + 1;
  // divider iteration count
  localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);

  localparam logic [FRAC_BITS-1:0] HALF_FIX = {1'b1, {(FRAC_BITS-1){1'b0}}};

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } state_t;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  point_valid;
    logic                  last_point;
  } pt_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/dda_div.sv
// restoring divider, one quotient bit per cycle, for the increment of one axis
`default_nettype none
`include "assert_macros.svh"

module dda_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [dda_pkg::COORD_BITS-1:0] mag,
  input  wire logic [dda_pkg::COORD_BITS-1:0] dvs_in,
  output logic      [dda_pkg::QUO_BITS-1:0]   quo,
  output dda_pkg::div_stat_t                  stat
);

  logic [dda_pkg::COORD_BITS-1:0] rem;
  logic [dda_pkg::COORD_BITS-1:0] dvs;
  logic [dda_pkg::CNT_BITS-1:0]   cnt;
  logic [dda_pkg::COORD_BITS:0]   rem2;
  logic [dda_pkg::COORD_BITS:0]   diff;
  logic                           qbit;

  // shift remainder, trial subtract
  always_comb begin
    rem2 = {rem, 1'b0};
    diff = rem2 - {1'b0, dvs};
    qbit = (rem2 >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        // integer bit: magnitude never exceeds the divisor
        dvs       <= dvs_in;
        cnt       <= dda_pkg::CNT_BITS'(dda_pkg::FRAC_BITS);
        stat.busy <= 1'b1;
        if (mag >= dvs_in) begin
          rem <= mag - dvs_in;
          quo <= dda_pkg::QUO_BITS'(1);
        end else begin
          rem <= mag;
          quo <= '0;
        end
      end else if (stat.busy) begin
        rem <= qbit ? diff[dda_pkg::COORD_BITS-1:0] : rem2[dda_pkg::COORD_BITS-1:0];
        quo <= {quo[dda_pkg::QUO_BITS-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == dda_pkg::CNT_BITS'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_CLK(a_busy_cnt, stat.busy |-> (cnt != '0), "divider busy with zero count")
  `ASSERT_CLK(a_start_idle, start |-> !stat.busy, "divider started while busy")
  `ASSERT_CLK(a_done_after_busy, stat.done |-> $past(stat.busy), "divider done without work")

endmodule

`default_nettype wire

FILE: sv/dda_line_point_generator.sv
// top level of the dda line point generator: request sequencer and point datapath
`default_nettype none
`include "assert_macros.svh"

// DDA line rasterizer. A start request (req_type 0) carries two endpoints and
// immediately returns the first endpoint as a point; last_point is set when the
// endpoints are equal, since such a line has only that one point. For a real
// line the block then computes the x and y increments, |d| * 2^FRAC_BITS / step
// with the sign of d, where step is the larger of |dx| and |dy|. Both come from
// one shared restoring divider that yields one quotient bit per cycle, x first
// and then y, so after a start transaction req_stall stays high until both
// divides are done. For a next-point request (req_type 1) the increments are
// added to the positions and the rounded point is returned, with last_point
// on the final one. A next-point request with no line in progress returns a
// transaction with point_valid 0 and all other fields 0. A start request while
// a line is in progress drops that line. Results sit in an output register; a
// new request is taken as soon as the held result is taken or in the same
// cycle it leaves.

module dda_line_point_generator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire dda_pkg::req_t req_data,
  output logic               pt_valid,
  input  wire logic          pt_stall,
  output dda_pkg::pt_t       pt_data
);

  dda_pkg::state_t state, state_next;

  // positions carry a built-in +1/2 so rounding is a plain slice
  logic signed [dda_pkg::POS_BITS-1:0]   x_pos, y_pos;
  logic signed [dda_pkg::INC_BITS-1:0]   x_inc, y_inc;
  logic        [dda_pkg::STEP_BITS-1:0]  steps_remaining;
  logic                                  line_active;
  logic                                  x_neg, y_neg;
  logic        [dda_pkg::COORD_BITS-1:0] ady;

  logic                                  req_acc;
  logic                                  is_start;
  logic                                  x_neg_c, y_neg_c;
  logic        [dda_pkg::COORD_BITS-1:0] adx_c, ady_c, step_c;
  logic signed [dda_pkg::POS_BITS-1:0]   x_sum, y_sum;
  logic        [dda_pkg::INC_BITS-1:0]   quo_ext, quo_neg;
  dda_pkg::pt_t                          pt_c;

  logic                                  div_start;
  logic        [dda_pkg::COORD_BITS-1:0] div_mag, div_dvs;
  logic        [dda_pkg::QUO_BITS-1:0]   div_quo;
  dda_pkg::div_stat_t                    div_stat;

  dda_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .mag    (div_mag),
    .dvs_in (div_dvs),
    .quo    (div_quo),
    .stat   (div_stat)
  );

  // handshake: busy through the divide, or output register held
  assign req_stall = (state != dda_pkg::ST_IDLE) || (pt_valid && pt_stall);
  assign req_acc   = req_valid && !req_stall;
  assign is_start  = (req_data.req_type == dda_pkg::REQ_START);

  // endpoint deltas and step count
  always_comb begin
    x_neg_c = (req_data.end_x < req_data.start_x);
    y_neg_c = (req_data.end_y < req_data.start_y);
    adx_c   = x_neg_c ? (req_data.start_x - req_data.end_x)
                      : (req_data.end_x - req_data.start_x);
    ady_c   = y_neg_c ? (req_data.start_y - req_data.end_y)
                      : (req_data.end_y - req_data.start_y);
    step_c  = (adx_c > ady_c) ? adx_c : ady_c;
  end

  // one dda step
  always_comb begin
    x_sum = x_pos + {{(dda_pkg::POS_BITS-dda_pkg::INC_BITS){x_inc[dda_pkg::INC_BITS-1]}}, x_inc};
    y_sum = y_pos + {{(dda_pkg::POS_BITS-dda_pkg::INC_BITS){y_inc[dda_pkg::INC_BITS-1]}}, y_inc};
  end

  // quotient to signed increment
  always_comb begin
    quo_ext = {1'b0, div_quo};
    quo_neg = ~quo_ext + 1'b1;
  end

  // result of the accepted request
  always_comb begin
    pt_c = '0;
    if (is_start) begin
      pt_c.point_x     = req_data.start_x;
      pt_c.point_y     = req_data.start_y;
      pt_c.point_valid = 1'b1;
      pt_c.last_point  = (step_c == '0);
    end else if (line_active) begin
      pt_c.point_x     = x_sum[dda_pkg::FRAC_BITS +: dda_pkg::COORD_BITS];
      pt_c.point_y     = y_sum[dda_pkg::FRAC_BITS +: dda_pkg::COORD_BITS];
      pt_c.point_valid = 1'b1;
      pt_c.last_point  = (steps_remaining == dda_pkg::STEP_BITS'(1));
    end
  end

  // sequencer: idle, divide for x, divide for y
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_mag    = adx_c;
    div_dvs    = step_c;
    case (state)
      dda_pkg::ST_IDLE: begin
        if (req_acc && is_start && (step_c != '0)) begin
          div_start  = 1'b1;
          state_next = dda_pkg::ST_DIV_X;
        end
      end
      dda_pkg::ST_DIV_X: begin
        // step count still sits in steps_remaining, no requests are taken meanwhile
        div_mag = ady;
        div_dvs = steps_remaining[dda_pkg::COORD_BITS-1:0];
        if (div_stat.done) begin
          div_start  = 1'b1;
          state_next = dda_pkg::ST_DIV_Y;
        end
      end
      dda_pkg::ST_DIV_Y: begin
        div_mag = ady;
        div_dvs = steps_remaining[dda_pkg::COORD_BITS-1:0];
        if (div_stat.done) begin
          state_next = dda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dda_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active     <= 1'b0;
      steps_remaining <= '0;
      x_pos           <= '0;
      y_pos           <= '0;
      x_inc           <= '0;
      y_inc           <= '0;
    end else begin
      if (req_acc && is_start) begin
        x_pos           <= {2'b00, req_data.start_x, dda_pkg::HALF_FIX};
        y_pos           <= {2'b00, req_data.start_y, dda_pkg::HALF_FIX};
        x_neg           <= x_neg_c;
        y_neg           <= y_neg_c;
        ady             <= ady_c;
        x_inc           <= '0;
        y_inc           <= '0;
        steps_remaining <= {1'b0, step_c};
        line_active     <= (step_c != '0);
      end else if (req_acc && line_active) begin
        x_pos           <= x_sum;
        y_pos           <= y_sum;
        steps_remaining <= steps_remaining - 1'b1;
        line_active     <= (steps_remaining != dda_pkg::STEP_BITS'(1));
      end
      if (div_stat.done && (state == dda_pkg::ST_DIV_X)) begin
        x_inc <= x_neg ? quo_neg : quo_ext;
      end
      if (div_stat.done && (state == dda_pkg::ST_DIV_Y)) begin
        y_inc <= y_neg ? quo_neg : quo_ext;
      end
    end
  end

  // output register, one transaction per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (req_acc) begin
      pt_valid <= 1'b1;
    end else if (!pt_stall) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      pt_data <= pt_c;
    end
  end

  `ASSERT_CLK(a_active_steps, line_active |-> (steps_remaining != '0),
              "line active with no steps left")
  `ASSERT_CLK(a_done_in_div, div_stat.done |->
              ((state == dda_pkg::ST_DIV_X) || (state == dda_pkg::ST_DIV_Y)),
              "divider result outside a divide state")
  `ASSERT_CLK(a_start_divides, (req_acc && is_start && (step_c != '0)) |=>
              ((state == dda_pkg::ST_DIV_X) && line_active),
              "start of a line did not begin the divide")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for the dda line point generator: random and directed requests, checked point by point
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dda_pkg::*;

  localparam int ITEMS_PER_PHASE = 325;
  // cycles in a row with no transaction on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT  = 4000;
  // a start transaction of a real line holds req_stall high until both divides are done
  localparam int DRAIN_CYCLES    = 2 * FRAC_BITS + 20;
  localparam int NUM_PHASES      = 4;

  typedef logic signed [POS_BITS-1:0]  pos_t;
  typedef logic signed [INC_BITS-1:0]  inc_t;
  typedef logic        [STEP_BITS-1:0] steps_t;
  typedef logic        [COORD_BITS-1:0] coord_t;

  // sender idle and receiver stall chances, in percent, one pair per phase
  int send_idle_by_phase[NUM_PHASES]   = '{0, 66, 0, 30};
  int recv_stall_by_phase[NUM_PHASES]  = '{0, 0, 66, 30};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data  = '0;
  logic pt_valid;
  logic pt_stall  = 1'b0;
  pt_t  pt_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  req_t pending_requests[$];
  pt_t  expected_points[$];
  int   queued_requests = 0;
  int   mismatches      = 0;
  int   quiet_cycles    = 0;
  pt_t  oldest_point;

  // line state mirrored from the block
  pos_t   x_pos      = '0;
  pos_t   y_pos      = '0;
  inc_t   x_inc      = '0;
  inc_t   y_inc      = '0;
  steps_t steps_left = '0;
  bit     drawing    = 1'b0;

  dda_line_point_generator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt_data   (pt_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // |d| * 2^FRAC_BITS / steps, truncated, carrying the sign of d
  function automatic inc_t slope_increment(logic signed [COORD_BITS:0] d, steps_t steps);
    logic [COORD_BITS-1:0]           mag;
    logic [COORD_BITS+FRAC_BITS-1:0] num;
    logic [QUO_BITS-1:0]             quo;
    mag = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
    num = {mag, {FRAC_BITS{1'b0}}};
    quo = QUO_BITS'(num / steps);
    return d[COORD_BITS] ? -inc_t'(quo) : inc_t'(quo);
  endfunction

  // floor(position + 1/2), kept to the coordinate width
  function automatic coord_t round_position(pos_t p);
    pos_t s;
    s = p + pos_t'(HALF_FIX);
    return s[FRAC_BITS +: COORD_BITS];
  endfunction

  // applies one request to the mirrored line state and returns the point it produces
  function automatic pt_t advance_line(req_t r);
    logic signed [COORD_BITS:0] dx, dy;
    steps_t adx, ady, steps;
    pt_t    p;
    p = '0;
    if (r.req_type == REQ_START) begin
      dx    = $signed({1'b0, r.end_x}) - $signed({1'b0, r.start_x});
      dy    = $signed({1'b0, r.end_y}) - $signed({1'b0, r.start_y});
      adx   = dx[COORD_BITS] ? STEP_BITS'(-dx) : STEP_BITS'(dx);
      ady   = dy[COORD_BITS] ? STEP_BITS'(-dy) : STEP_BITS'(dy);
      steps = (adx > ady) ? adx : ady;
      x_pos = pos_t'({r.start_x, {FRAC_BITS{1'b0}}});
      y_pos = pos_t'({r.start_y, {FRAC_BITS{1'b0}}});
      if (steps == '0) begin
        // degenerate line: a single point, which is also the last
        x_inc      = '0;
        y_inc      = '0;
        steps_left = '0;
        drawing    = 1'b0;
      end else begin
        x_inc      = slope_increment(dx, steps);
        y_inc      = slope_increment(dy, steps);
        steps_left = steps;
        drawing    = 1'b1;
      end
      p.point_x     = round_position(x_pos);
      p.point_y     = round_position(y_pos);
      p.point_valid = 1'b1;
      p.last_point  = !drawing;
    end else if (drawing) begin
      x_pos      = x_pos + x_inc;
      y_pos      = y_pos + y_inc;
      steps_left = steps_left - 1'b1;
      if (steps_left == '0) drawing = 1'b0;
      p.point_x     = round_position(x_pos);
      p.point_y     = round_position(y_pos);
      p.point_valid = 1'b1;
      p.last_point  = !drawing;
    end
    // a next request with no line in progress leaves p all zero
    return p;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // request driver: holds the payload while stalled, picks the next one otherwise
  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      x_pos      = '0;
      y_pos      = '0;
      x_inc      = '0;
      y_inc      = '0;
      steps_left = '0;
      drawing    = 1'b0;
    end else begin
      // accepted request: predict its point now, in acceptance order
      if (req_valid && !req_stall) expected_points.push_back(advance_line(req_data));
      if (!req_valid || !req_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_data  <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // point monitor: compares each accepted point with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pt_stall <= 1'b0;
    end else begin
      if (pt_valid && !pt_stall) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point transaction: x %0d y %0d valid %0b last %0b",
                 pt_data.point_x, pt_data.point_y, pt_data.point_valid, pt_data.last_point);
          mismatches++;
        end else begin
          oldest_point = expected_points.pop_front();
          check_field("point_x", oldest_point.point_x, pt_data.point_x);
          check_field("point_y", oldest_point.point_y, pt_data.point_y);
          check_field("point_valid", oldest_point.point_valid, pt_data.point_valid);
          check_field("last_point", oldest_point.last_point, pt_data.last_point);
        end
      end
      pt_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (pt_valid && !pt_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_request(logic rt, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    req_t r;
    r.req_type = rt;
    r.start_x  = sx;
    r.start_y  = sy;
    r.end_x    = ex;
    r.end_y    = ey;
    pending_requests.push_back(r);
    queued_requests++;
  endtask

  // next-point request; the endpoint fields are ignored, so they carry noise
  task automatic push_next();
    push_request(REQ_NEXT, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom));
  endtask

  function automatic coord_t near_coord(coord_t c, int span);
    int lo, hi;
    lo = (int'(c) - span < 0) ? 0 : int'(c) - span;
    hi = (int'(c) + span > 1023) ? 1023 : int'(c) + span;
    return coord_t'($urandom_range(hi, lo));
  endfunction

  initial begin
    int first, pick, span, steps, count, ddx, ddy;
    coord_t sx, sy, ex, ey;

    // directed part, run without idling
    push_request(REQ_NEXT, '1, '1, '1, '1);        // next with no line yet
    push_request(REQ_START, '0, '0, '0, '0);       // equal endpoints at the origin
    push_next();                                   // idle again after a one-point line
    push_request(REQ_START, '1, '1, '1, '1);       // equal endpoints at the far corner
    push_request(REQ_START, '0, '0, '1, '1);       // full diagonal, dropped after three
    repeat (3) push_next();
    push_request(REQ_START, '1, '1, '0, '0);       // restart mid-line, negative steps
    repeat (2) push_next();
    push_request(REQ_START, '0, '1, '1, '0);
    push_next();
    push_request(REQ_START, '1, '0, '0, '1);
    push_next();
    push_request(REQ_START, 10'd5, 10'd5, 10'd8, 10'd3);   // shallow, traced past its end
    repeat (4) push_next();
    push_request(REQ_START, 10'd1023, 10'd0, 10'd1020, 10'd2);
    repeat (4) push_next();
    push_request(REQ_START, 10'd10, 10'd10, 10'd11, 10'd14); // steep
    repeat (4) push_next();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk);
      send_idle_pct  = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      first = queued_requests;
      while (queued_requests - first < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 90) begin
          // a line: mostly short, a few long ones
          span = $urandom_range(99);
          span = (span < 70) ? 8 : (span < 97) ? 64 : 1023;
          sx = coord_t'($urandom);
          sy = coord_t'($urandom);
          ex = near_coord(sx, span);
          ey = near_coord(sy, span);
          ddx = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
          ddy = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
          steps = (ddx > ddy) ? ddx : ddy;
          push_request(REQ_START, sx, sy, ex, ey);
          if (pick < 75) count = steps + $urandom_range(2);       // full trace, maybe overrun
          else count = (steps == 0) ? 0 : $urandom_range(steps - 1); // cut short by a restart
          repeat (count) push_next();
        end else begin
          // noise: requests of either kind with arbitrary fields
          repeat ($urandom_range(4, 1))
            push_request(logic'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom));
        end
      end
      while (pending_requests.size() != 0) @(negedge clk);
    end

    while (expected_points.size() != 0 || req_valid) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_points.size() != 0) begin
      $error("%0d expected point transactions never arrived", expected_points.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
